FILE: rtl/core/stmch_pkg.sv
// shared types and constants for the sparse tile map chunk hash
// no dependencies
`default_nettype none
package stmch_pkg;
   localparam int KEY_BITS = 25;
   localparam int COORD_BITS = 29;
   localparam int ZB = 25;
   localparam int VAL_BITS = 8;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_LOAD, CMD_RD_META, CMD_FOLLOW, CMD_CLAIM_HEAD, CMD_CLAIM_OVF, CMD_FILL,
      CMD_TILE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      logic in_use;
      logic match;
      logic has_next;
      logic pool_full;
      logic fill_done;
      logic is_write;
   } stat_type;
endpackage
`default_nettype wire

FILE: rtl/core/stmch_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`default_nettype none
module stmch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/stmch_datapath.sv
// datapath: key, hash, chain metadata, tile store
// uses stmch_pkg and stmch_ram
`default_nettype none
module stmch_datapath #(
   parameter int CHUNK_SHIFT = 4,
   parameter int HASH_SLOTS = 64,
   parameter int OVERFLOW_CHUNKS = 64,
   parameter int TILE_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire stmch_pkg::cmd_type     cmd,
   output      stmch_pkg::stat_type    stat,
   input  wire logic                   req_mode,
   input  wire logic [28:0]            req_tile_x,
   input  wire logic [28:0]            req_tile_y,
   input  wire logic [24:0]            req_tile_z,
   input  wire logic [7:0]             req_write_value,
   output      logic [7:0]             res_value,
   output      logic                   res_found
);
   localparam int POOL = HASH_SLOTS + OVERFLOW_CHUNKS;
   localparam int PB = $clog2(POOL);
   localparam int PW = 2 * CHUNK_SHIFT;
   localparam int TA = PB + PW;
   localparam int OB = $clog2(OVERFLOW_CHUNKS + 1);
   localparam int KB = stmch_pkg::COORD_BITS - CHUNK_SHIFT;
   localparam int ZB = stmch_pkg::ZB;
   localparam logic [32:0] VMAX = (33'd1 << TILE_BITS) - 33'd1;

   logic [KB-1:0] cx_ff, cy_ff;
   logic [ZB-1:0] cz_ff;
   logic [PW-1:0] pos_ff;
   logic [7:0] wv_ff;
   logic is_write_ff;
   logic [PB-1:0] cur_ff, cur_in;
   logic [OB-1:0] ovf_ff;
   logic [PW:0] fill_ff;
   logic [POOL-1:0] in_use_ff, nv_ff;
   logic [7:0] val_ff;
   logic found_ff;

   // hash of the chunk key, wrapped to 32 bits
   logic [31:0] hash;
   logic [KB-1:0] kx, ky;
   assign kx = KB'(req_tile_x >> CHUNK_SHIFT);
   assign ky = KB'(req_tile_y >> CHUNK_SHIFT);
   assign hash = 32'd19 * 32'(kx) + 32'd7 * 32'(ky) + 32'd3 * 32'(req_tile_z);
   logic [PB-1:0] slot;
   assign slot = PB'(hash % 32'(HASH_SLOTS));

   // metadata ram word: key x, y, z
   localparam int MW = 2 * KB + ZB;
   logic meta_we;
   logic [PB-1:0] meta_wa;
   logic [MW-1:0] meta_wd, meta_rd;
   stmch_ram #(.WIDTH(MW), .DEPTH(POOL)) u_meta (
      .clock(clock), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
      .raddr(cur_in), .rdata(meta_rd));

   // chain links in a ram of their own, so a link update keeps the key
   logic link_we;
   logic [PB-1:0] link_wa, link_wd, link_rd;
   stmch_ram #(.WIDTH(PB), .DEPTH(POOL)) u_link (
      .clock(clock), .we(link_we), .waddr(link_wa), .wdata(link_wd),
      .raddr(cur_in), .rdata(link_rd));

   logic tile_we;
   logic [TA-1:0] tile_wa, tile_ra;
   logic [TILE_BITS-1:0] tile_wd, tile_rd;
   stmch_ram #(.WIDTH(TILE_BITS), .DEPTH(POOL << PW)) u_tile (
      .clock(clock), .we(tile_we), .waddr(tile_wa), .wdata(tile_wd),
      .raddr(tile_ra), .rdata(tile_rd));

   logic [PB-1:0] newc;
   assign newc = PB'(HASH_SLOTS) + PB'(ovf_ff);
   logic [TILE_BITS-1:0] wsat;
   assign wsat = (33'(wv_ff) > VMAX) ? TILE_BITS'(VMAX) : TILE_BITS'(wv_ff);

   always_comb begin
      cur_in = cur_ff;
      meta_we = 1'b0;
      meta_wa = cur_ff;
      meta_wd = {cx_ff, cy_ff, cz_ff};
      link_we = 1'b0;
      link_wa = cur_ff;
      link_wd = newc;
      tile_we = 1'b0;
      tile_wa = {cur_ff, PW'(fill_ff)};
      tile_wd = TILE_BITS'(1);
      tile_ra = {cur_ff, pos_ff};
      case (cmd.op)
         stmch_pkg::CMD_LOAD: cur_in = slot;
         stmch_pkg::CMD_FOLLOW: cur_in = link_rd;
         stmch_pkg::CMD_CLAIM_HEAD: meta_we = 1'b1;
         stmch_pkg::CMD_CLAIM_OVF: begin
            meta_we = 1'b1;
            meta_wa = newc;
            link_we = 1'b1;
            cur_in = newc;
         end
         stmch_pkg::CMD_FILL: tile_we = 1'b1;
         stmch_pkg::CMD_TILE: begin
            tile_we = is_write_ff;
            tile_wa = {cur_ff, pos_ff};
            tile_wd = wsat;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.op == stmch_pkg::CMD_LOAD) begin
         cx_ff <= kx;
         cy_ff <= ky;
         cz_ff <= ZB'(req_tile_z);
         pos_ff <= {req_tile_y[CHUNK_SHIFT-1:0], req_tile_x[CHUNK_SHIFT-1:0]};
         wv_ff <= req_write_value;
         is_write_ff <= req_mode;
      end
      if (cmd.op == stmch_pkg::CMD_TILE) val_ff <= is_write_ff ? 8'(wsat) : 8'(tile_rd);
      if (reset) begin
         ovf_ff <= '0;
         in_use_ff <= '0;
         nv_ff <= '0;
         fill_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         case (cmd.op)
            stmch_pkg::CMD_LOAD: fill_ff <= '0;
            stmch_pkg::CMD_CLAIM_HEAD: begin
               in_use_ff[cur_ff] <= 1'b1;
               nv_ff[cur_ff] <= 1'b0;
            end
            stmch_pkg::CMD_CLAIM_OVF: begin
               in_use_ff[newc] <= 1'b1;
               nv_ff[newc] <= 1'b0;
               nv_ff[cur_ff] <= 1'b1;
               ovf_ff <= ovf_ff + OB'(1);
            end
            stmch_pkg::CMD_FILL: fill_ff <= fill_ff + (PW+1)'(1);
            stmch_pkg::CMD_TILE: found_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign stat.in_use = in_use_ff[cur_ff];
   assign stat.match = meta_rd == {cx_ff, cy_ff, cz_ff};
   assign stat.has_next = nv_ff[cur_ff] && (32'(link_rd) < 32'(POOL));
   assign stat.pool_full = 32'(ovf_ff) >= 32'(OVERFLOW_CHUNKS);
   assign stat.fill_done = fill_ff[PW];
   assign stat.is_write = is_write_ff;
   assign res_value = val_ff;
   assign res_found = found_ff;
endmodule
`default_nettype wire

FILE: rtl/core/stmch_ctrl.sv
// controller state machine for the chunk hash walk
// uses stmch_pkg
`default_nettype none
module stmch_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      stmch_pkg::cmd_type  cmd,
   input  wire stmch_pkg::stat_type stat,
   output      logic [1:0]          res_status
);
   typedef enum logic [2:0] {
      S_IDLE, S_META, S_CHECK, S_FILL, S_TILE
   } state_type;
   state_type state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic rv_ff, rv_in;
   logic out_free;

   // result register free now or emptied at this edge
   assign out_free = !rv_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      rv_in = rv_ff && !rsp_ready;
      cmd.op = stmch_pkg::CMD_NONE;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op = stmch_pkg::CMD_LOAD;
            state_in = S_META;
         end
         S_META: state_in = S_CHECK;
         S_CHECK: begin
            if (!stat.in_use) begin
               if (stat.is_write) begin
                  cmd.op = stmch_pkg::CMD_CLAIM_HEAD;
                  state_in = S_FILL;
               end else if (out_free) begin
                  status_in = stmch_pkg::ST_MISS;
                  rv_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (stat.match) begin
               state_in = S_TILE;
            end else if (stat.has_next) begin
               cmd.op = stmch_pkg::CMD_FOLLOW;
               state_in = S_META;
            end else if (!stat.is_write) begin
               if (out_free) begin
                  status_in = stmch_pkg::ST_MISS;
                  rv_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (stat.pool_full) begin
               if (out_free) begin
                  status_in = stmch_pkg::ST_DROP;
                  rv_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op = stmch_pkg::CMD_CLAIM_OVF;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (stat.fill_done) state_in = S_TILE;
            else cmd.op = stmch_pkg::CMD_FILL;
         end
         S_TILE: if (out_free) begin
            cmd.op = stmch_pkg::CMD_TILE;
            status_in = stmch_pkg::ST_OK;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         status_ff <= stmch_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         status_ff <= status_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign res_status = status_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |-> cmd.op != stmch_pkg::CMD_TILE) else $error("result overwritten");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(status_ff)) else $error("result lost");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL && stat.fill_done |=> state_ff == S_TILE) else $error("fill");
endmodule
`default_nettype wire

FILE: rtl/core/sparse_tile_map_chunk_hash.sv
// top level of the sparse tile map chunk hash
// uses stmch_pkg, stmch_ctrl, stmch_datapath, stmch_ram
`default_nettype none
// one read or write of a tile a word; the chunk key hashes to a head slot and
// the chain is walked one chunk at a time, a metadata ram read state then a
// compare state; a hit then takes the tile state, which registers the result
// word, and the next word can be taken once it is. a miss on an empty head
// slot answers from the compare state. a write to a new chunk first fills its
// 2^(2*CHUNK_SHIFT) tiles with 1, one tile ram write per cycle. status 1 is
// a read miss, 2 a write dropped with the overflow pool full. the result word
// sits in its own register, so the next word is taken while it waits; that
// word's walk then holds before its result until the waiting word has left.
module sparse_tile_map_chunk_hash #(
   parameter int CHUNK_SHIFT = 4,
   parameter int HASH_SLOTS = 64,
   parameter int OVERFLOW_CHUNKS = 64,
   parameter int TILE_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_mode,
   input  wire logic [28:0] req_tile_x,
   input  wire logic [28:0] req_tile_y,
   input  wire logic [24:0] req_tile_z,
   input  wire logic [7:0]  req_write_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_tile_value,
   output      logic        rsp_is_passable,
   output      logic [1:0]  rsp_status
);
   stmch_pkg::cmd_type cmd;
   stmch_pkg::stat_type stat;
   logic [7:0] value;
   logic found;

   stmch_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .stat, .res_status(rsp_status));

   stmch_datapath #(
      .CHUNK_SHIFT(CHUNK_SHIFT), .HASH_SLOTS(HASH_SLOTS),
      .OVERFLOW_CHUNKS(OVERFLOW_CHUNKS), .TILE_BITS(TILE_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .stat, .req_mode, .req_tile_x, .req_tile_y,
      .req_tile_z, .req_write_value, .res_value(value), .res_found(found));

   // misses and dropped writes report zero
   assign rsp_tile_value = (rsp_status == stmch_pkg::ST_OK) ? value : 8'd0;
   assign rsp_is_passable = (rsp_status == stmch_pkg::ST_OK) && found &&
      (value == 8'd1 || value == 8'd3 || value == 8'd4);
endmodule
`default_nettype wire
